### sv/lprf_pkg.sv
// Shared types and constants for the length-prefixed ring FIFO.
`timescale 1ns / 1ps

package lprf_pkg;

  localparam int unsigned LEN_W         = 16;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned PREFIX_BYTES  = 2;
  localparam int unsigned MIN_RING_SIZE = 4;

  typedef enum logic [1:0] {
    OP_WR_BEGIN = 2'd0,
    OP_WR_BYTE  = 2'd1,
    OP_RD_BEGIN = 2'd2,
    OP_RD_BYTE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_ZERO_LEN     = 3'd2,
    ST_NO_SPACE     = 3'd3,
    ST_SHORT_PREFIX = 3'd4,
    ST_TRUNCATED    = 3'd5,
    ST_DISCARDED    = 3'd6,
    ST_NO_TRANSFER  = 3'd7
  } status_t;

endpackage

### sv/lprf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lprf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/length_prefixed_ring_fifo.sv
// Top level of the length-prefixed ring FIFO: handshake, pointer state and ring memories.
//
// Accepts one transaction per cycle while the output is not held by m_tready, and returns
// one result per transaction, loaded into the input register at acceptance and then into
// the result register, which drives the output. The pointer update of the transaction in
// the input register feeds the read addresses of the two ring memories for the transaction
// accepted in the same cycle, and that loop sets the rate.
// Message lengths live in a separate length memory indexed by record start, so a read
// begin needs one memory read and a write begin one memory write. Writing ring_size
// empties the ring; memory contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module length_prefixed_ring_fifo
  import lprf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // length[15:0], data_byte[23:16]
  input  logic [1:0]   s_tuser,   // op[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata,   // msg_length[15:0], data_out[23:16]
  output logic [2:0]   m_tuser,   // status[2:0]
  output logic         m_tlast,
  input  logic         cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned SW = $clog2(RING_DEPTH + 1);
  localparam int unsigned XW = ((AW > LEN_W) ? AW : LEN_W) + 2;

  logic [SW-1:0]    size;
  logic [AW-1:0]    rp, wp, wc, rc;
  logic [AW-1:0]    rp_next, wp_next, wc_next, rc_next;
  logic [LEN_W-1:0] wrem, rrem, wrem_next, rrem_next;

  logic             a_valid;
  op_t              a_op;
  logic [LEN_W-1:0] a_length;
  logic [BYTE_W-1:0] a_byte;

  logic             out_valid;
  status_t          out_status;
  logic [LEN_W-1:0] out_mlen;
  logic [BYTE_W-1:0] out_dout;
  logic             out_last;

  status_t          st;
  logic [LEN_W-1:0] mlen;
  logic [BYTE_W-1:0] dout;
  logic             last;

  logic             a_fire, in_fire;
  logic [XW-1:0]    used, free_bytes, body_sum;
  logic [AW-1:0]    body;
  logic [LEN_W-1:0] found;
  logic [BYTE_W-1:0] byte_rdata;
  logic             byte_we, len_we;
  logic [SW-1:0]    cfg_size;

  function automatic logic [AW-1:0] wrap(input logic [XW-1:0] s, input logic [XW-1:0] sz);
    logic [XW-1:0] r;
    r = (s >= sz) ? s - sz : s;
    return r[AW-1:0];
  endfunction

  assign a_fire   = a_valid && (!out_valid || m_tready);
  assign s_tready = !a_valid || a_fire;
  assign in_fire  = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_dout, out_mlen};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  assign used = (wp >= rp) ? XW'(wp) - XW'(rp) : XW'(wp) + XW'(size) - XW'(rp);
  assign free_bytes = XW'(size) - XW'(1) - used;
  assign body     = wrap(XW'(rp) + XW'(PREFIX_BYTES), XW'(size));
  assign body_sum = XW'(body) + XW'(found);

  always_comb begin
    rp_next   = rp;
    wp_next   = wp;
    wc_next   = wc;
    rc_next   = rc;
    wrem_next = wrem;
    rrem_next = rrem;
    st        = ST_OK;
    mlen      = '0;
    dout      = '0;
    last      = 1'b0;
    byte_we   = 1'b0;
    len_we    = 1'b0;
    if (a_fire) begin
      unique case (a_op)
        OP_WR_BEGIN: begin
          if (a_length == '0) begin
            st = ST_ZERO_LEN;
          end else if (free_bytes < XW'(a_length) + XW'(PREFIX_BYTES)) begin
            st = ST_NO_SPACE;
          end else begin
            len_we    = 1'b1;
            wc_next   = wrap(XW'(wp) + XW'(PREFIX_BYTES), XW'(size));
            wrem_next = a_length;
          end
        end
        OP_WR_BYTE: begin
          if (wrem == '0) begin
            st = ST_NO_TRANSFER;
          end else begin
            byte_we   = 1'b1;
            wc_next   = wrap(XW'(wc) + XW'(1), XW'(size));
            wrem_next = wrem - LEN_W'(1);
            if (wrem_next == '0) begin
              wp_next = wc_next;
              last    = 1'b1;
            end
          end
        end
        OP_RD_BEGIN: begin
          rrem_next = '0;
          if (a_length == '0) begin
            st = ST_ZERO_LEN;
          end else if (used == '0) begin
            st = ST_EMPTY;
          end else if (used < XW'(PREFIX_BYTES)) begin
            st = ST_SHORT_PREFIX;
          end else begin
            mlen = found;
            if (XW'(found) > used - XW'(PREFIX_BYTES)) begin
              st = ST_TRUNCATED;
            end else if (found > a_length) begin
              rp_next = wrap(body_sum, XW'(size));
              st      = ST_DISCARDED;
            end else if (found == '0) begin
              rp_next = body;
              last    = 1'b1;
            end else begin
              rc_next   = body;
              rrem_next = found;
            end
          end
        end
        OP_RD_BYTE: begin
          if (rrem == '0) begin
            st = ST_NO_TRANSFER;
          end else begin
            dout      = byte_rdata;
            rc_next   = wrap(XW'(rc) + XW'(1), XW'(size));
            rrem_next = rrem - LEN_W'(1);
            if (rrem_next == '0) begin
              rp_next = rc_next;
              last    = 1'b1;
            end
          end
        end
        default: st = ST_NO_TRANSFER;
      endcase
    end
  end

  always_comb begin
    if (32'(cfg_wdata) < 32'(MIN_RING_SIZE)) begin
      cfg_size = SW'(MIN_RING_SIZE);
    end else if (32'(cfg_wdata) > 32'(RING_DEPTH)) begin
      cfg_size = SW'(RING_DEPTH);
    end else begin
      cfg_size = SW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SW'(RING_DEPTH);
      rp   <= '0;
      wp   <= '0;
      wc   <= '0;
      rc   <= '0;
      wrem <= '0;
      rrem <= '0;
    end else if (cfg_wen) begin
      size <= cfg_size;
      rp   <= '0;
      wp   <= '0;
      wc   <= '0;
      rc   <= '0;
      wrem <= '0;
      rrem <= '0;
    end else begin
      rp   <= rp_next;
      wp   <= wp_next;
      wc   <= wc_next;
      rc   <= rc_next;
      wrem <= wrem_next;
      rrem <= rrem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid <= 1'b1;
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
      if (a_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op     <= op_t'(s_tuser);
      a_length <= s_tdata[15:0];
      a_byte   <= s_tdata[23:16];
    end
    if (a_fire) begin
      out_status <= st;
      out_mlen   <= mlen;
      out_dout   <= dout;
      out_last   <= last;
    end
  end

  lprf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (wc),
    .wdata (a_byte),
    .re    (in_fire),
    .raddr (rc_next),
    .rdata (byte_rdata)
  );

  lprf_ram #(
    .WIDTH (LEN_W),
    .DEPTH (RING_DEPTH)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (wp),
    .wdata (a_length),
    .re    (in_fire),
    .raddr (rp_next),
    .rdata (found)
  );

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (rst)
    (XW'(rp) < XW'(size)) && (XW'(wp) < XW'(size)))
    else $error("committed pointer outside ring");

  a_cfg_empties: assert property (@(posedge clk) disable iff (rst)
    cfg_wen |=> (rp == '0) && (wp == '0) && (wrem == '0) && (rrem == '0))
    else $error("ring not emptied after size write");

  a_fail_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (!m_tlast && (m_tdata[23:16] == '0)))
    else $error("failed transaction carries data or last");

  a_mlen_status: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[15:0] != '0)) |->
      ((m_tuser == ST_OK) || (m_tuser == ST_TRUNCATED) || (m_tuser == ST_DISCARDED)))
    else $error("message length reported with wrong status");

endmodule

### tb/sv/tb_length_prefixed_ring_fifo.sv
// Self-checking testbench for the length-prefixed ring FIFO: directed and random streams.
`timescale 1ns / 1ps

module tb_length_prefixed_ring_fifo;
  import lprf_pkg::*;

  localparam int unsigned RING_DEPTH = 4096;
  localparam int unsigned PTR_W      = 12;

  typedef struct packed {
    op_t               op;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;
  } ring_txn_t;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  msg_length;
    logic [BYTE_W-1:0] data_out;
    logic              last;
  } ring_resp_t;

  typedef struct packed {
    logic [CFG_W-1:0] ring_size;
    logic [PTR_W-1:0] rd_ptr, wr_ptr, wr_cur, rd_cur;
    logic [LEN_W-1:0] wr_left, rd_left;
  } ring_state_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic [2:0]        m_tuser;
  logic              m_tlast;
  logic              cfg_wen = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  logic [BYTE_W-1:0] model_mem [RING_DEPTH];
  logic [BYTE_W-1:0] plan_mem  [RING_DEPTH];
  ring_state_t       model_st;
  ring_state_t       plan_st;
  ring_txn_t         pending_txns [$];
  ring_txn_t         bus_txn;
  ring_resp_t        expected_resps [$];
  int                error_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                hold_rx = 1'b0;

  length_prefixed_ring_fifo #(
    .RING_DEPTH(RING_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int ring_bytes(logic [CFG_W-1:0] raw);
    if (raw < MIN_RING_SIZE) return MIN_RING_SIZE;
    if (raw > RING_DEPTH) return RING_DEPTH;
    return int'(raw);
  endfunction

  function automatic logic [PTR_W-1:0] wrap(int p, int n, int ring_len);
    return PTR_W'((p + n) % ring_len);
  endfunction

  function automatic void mem_put(bit plan, logic [PTR_W-1:0] a, logic [BYTE_W-1:0] v);
    if (plan) plan_mem[a] = v;
    else model_mem[a] = v;
  endfunction

  function automatic logic [BYTE_W-1:0] mem_get(bit plan, logic [PTR_W-1:0] a);
    return plan ? plan_mem[a] : model_mem[a];
  endfunction

  // One transaction against either the stimulus plan or the checking model.
  function automatic ring_resp_t ring_response(bit plan, ring_txn_t t);
    ring_state_t      st;
    ring_resp_t       r;
    int               ring_len;
    int               used;
    int               found;
    logic [PTR_W-1:0] body;
    st = plan ? plan_st : model_st;
    ring_len = ring_bytes(st.ring_size);
    used = (int'(st.wr_ptr) + ring_len - int'(st.rd_ptr)) % ring_len;
    r = '0;
    case (t.op)
      OP_WR_BEGIN: begin
        if (t.length == 0) begin
          r.status = ST_ZERO_LEN;
        end else if (ring_len - 1 - used < int'(t.length) + PREFIX_BYTES) begin
          r.status = ST_NO_SPACE;
        end else begin
          mem_put(plan, st.wr_ptr, t.length[7:0]);
          mem_put(plan, wrap(st.wr_ptr, 1, ring_len), t.length[15:8]);
          st.wr_cur = wrap(st.wr_ptr, PREFIX_BYTES, ring_len);
          st.wr_left = t.length;
        end
      end
      OP_WR_BYTE: begin
        if (st.wr_left == 0) begin
          r.status = ST_NO_TRANSFER;
        end else begin
          mem_put(plan, st.wr_cur, t.data_byte);
          st.wr_cur = wrap(st.wr_cur, 1, ring_len);
          st.wr_left = st.wr_left - 1'b1;
          if (st.wr_left == 0) begin
            st.wr_ptr = st.wr_cur;
            r.last = 1'b1;
          end
        end
      end
      OP_RD_BEGIN: begin
        st.rd_left = '0;
        if (t.length == 0) begin
          r.status = ST_ZERO_LEN;
        end else if (used == 0) begin
          r.status = ST_EMPTY;
        end else if (used < PREFIX_BYTES) begin
          r.status = ST_SHORT_PREFIX;
        end else begin
          found = int'({mem_get(plan, wrap(st.rd_ptr, 1, ring_len)), mem_get(plan, st.rd_ptr)});
          body = wrap(st.rd_ptr, PREFIX_BYTES, ring_len);
          r.msg_length = LEN_W'(found);
          if (found > used - PREFIX_BYTES) begin
            r.status = ST_TRUNCATED;
          end else if (found > t.length) begin
            st.rd_ptr = wrap(body, found, ring_len);
            r.status = ST_DISCARDED;
          end else if (found == 0) begin
            st.rd_ptr = body;
            r.last = 1'b1;
          end else begin
            st.rd_cur = body;
            st.rd_left = LEN_W'(found);
          end
        end
      end
      OP_RD_BYTE: begin
        if (st.rd_left == 0) begin
          r.status = ST_NO_TRANSFER;
        end else begin
          r.data_out = mem_get(plan, st.rd_cur);
          st.rd_cur = wrap(st.rd_cur, 1, ring_len);
          st.rd_left = st.rd_left - 1'b1;
          if (st.rd_left == 0) begin
            st.rd_ptr = st.rd_cur;
            r.last = 1'b1;
          end
        end
      end
    endcase
    if (plan) plan_st = st;
    else model_st = st;
    return r;
  endfunction

  task automatic queue_txn(op_t op, int length, int data_byte);
    ring_txn_t t;
    t.op = op;
    t.length = LEN_W'(length);
    t.data_byte = BYTE_W'(data_byte);
    void'(ring_response(1'b1, t));
    pending_txns.push_back(t);
  endtask

  task automatic write_ring_size(int unsigned value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
    model_st = '0;
    model_st.ring_size = CFG_W'(value);
    plan_st = model_st;
  endtask

  task automatic queue_directed();
    queue_txn(OP_RD_BYTE, 16'hFFFF, 8'hFF);
    queue_txn(OP_WR_BYTE, 0, 0);
    queue_txn(OP_RD_BEGIN, 16'hFFFF, 0);
    queue_txn(OP_WR_BEGIN, 0, 0);
    queue_txn(OP_WR_BEGIN, 16'hFFFF, 0);
    // abandon a partial message, restart at the committed pointer
    queue_txn(OP_WR_BEGIN, 2, 0);
    queue_txn(OP_WR_BYTE, 0, 8'h11);
    queue_txn(OP_WR_BEGIN, 3, 0);
    queue_txn(OP_WR_BYTE, 0, 8'h00);
    queue_txn(OP_WR_BYTE, 16'hFFFF, 8'hFF);
    queue_txn(OP_WR_BYTE, 0, 8'hA5);
    queue_txn(OP_WR_BEGIN, 5, 0);
    for (int i = 0; i < 5; i++) queue_txn(OP_WR_BYTE, i, 8'h30 + i);
    queue_txn(OP_RD_BEGIN, 0, 0);
    queue_txn(OP_RD_BEGIN, 3, 0);
    queue_txn(OP_RD_BYTE, 0, 0);
    queue_txn(OP_RD_BEGIN, 16'hFFFF, 0);
    for (int i = 0; i < 3; i++) queue_txn(OP_RD_BYTE, 0, 0);
    // drop the oversized record, then find the ring empty
    queue_txn(OP_RD_BEGIN, 4, 0);
    queue_txn(OP_RD_BEGIN, 1, 0);
  endtask

  task automatic queue_random(int count);
    int start;
    int ring_len;
    int used;
    int lim;
    int len;
    int cut;
    int found;
    int cap;
    int roll;
    int pick;
    start = pending_txns.size();
    while (pending_txns.size() - start < count) begin
      ring_len = ring_bytes(plan_st.ring_size);
      used = (int'(plan_st.wr_ptr) + ring_len - int'(plan_st.rd_ptr)) % ring_len;
      lim = ring_len - 1 - used - PREFIX_BYTES;
      roll = $urandom_range(99);
      pick = $urandom_range(19);
      if (roll < 10) begin
        queue_txn(op_t'($urandom_range(3)),
                  $urandom_range(1) ? $urandom_range(65535) : $urandom_range(8),
                  $urandom_range(255));
      end else if (roll < 55) begin
        if (lim < 1 || pick < 2) begin
          queue_txn(OP_WR_BEGIN, (lim < 1) ? $urandom_range(65535, 1) :
                    $urandom_range(65535, lim + 1), $urandom_range(255));
        end else begin
          if (pick < 4 && lim <= 300) len = lim;
          else if (pick < 8) len = $urandom_range((lim < 200) ? lim : 200, 1);
          else len = $urandom_range((lim < 12) ? lim : 12, 1);
          queue_txn(OP_WR_BEGIN, len, $urandom_range(255));
          cut = ($urandom_range(11) == 0) ? $urandom_range(len - 1) : len;
          for (int i = 0; i < cut; i++)
            queue_txn(OP_WR_BYTE, $urandom_range(65535), $urandom_range(255));
        end
      end else begin
        if (used == 0 || pick == 0) begin
          queue_txn(OP_RD_BEGIN, (pick == 0) ? 0 : $urandom_range(65535, 1),
                    $urandom_range(255));
        end else begin
          found = int'({plan_mem[wrap(plan_st.rd_ptr, 1, ring_len)],
                        plan_mem[plan_st.rd_ptr]});
          if (pick < 3) cap = $urandom_range(found - 1);
          else if (pick < 7) cap = found;
          else if (pick < 9) cap = 65535;
          else cap = $urandom_range(65535, found);
          queue_txn(OP_RD_BEGIN, cap, $urandom_range(255));
          if (cap >= found) begin
            cut = ($urandom_range(11) == 0) ? $urandom_range(found - 1) : found;
            for (int i = 0; i < cut; i++)
              queue_txn(OP_RD_BYTE, $urandom_range(65535), $urandom_range(255));
          end
        end
      end
    end
  endtask

  task automatic run_phase(bit do_cfg, int unsigned size_val, int sidle, int rstall,
                           bit directed, int count, bit long_hold);
    if (do_cfg) write_ring_size(size_val);
    @(negedge clk);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    if (directed) queue_directed();
    queue_random(count);
    if (long_hold) begin
      // hold the output side while the input keeps offering, so the block backs up
      hold_rx = 1'b1;
      repeat (400) @(negedge clk);
      hold_rx = 1'b0;
    end
    wait (pending_txns.size() == 0 && s_tvalid == 1'b0 && expected_resps.size() == 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_resps.push_back(ring_response(1'b0, bus_txn));
      if (!s_tvalid || s_tready) begin
        if (pending_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_txn = pending_txns.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= bus_txn.op;
          s_tdata <= {bus_txn.data_byte, bus_txn.length};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ring_resp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected transaction: status %0d msg_length %0d", m_tuser, m_tdata[15:0]);
          error_count++;
        end else begin
          want = expected_resps.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            error_count++;
          end
          if (m_tdata[15:0] !== want.msg_length) begin
            $error("msg_length: expected %0d, got %0d", want.msg_length, m_tdata[15:0]);
            error_count++;
          end
          if (m_tdata[23:16] !== want.data_out) begin
            $error("data_out: expected %0d, got %0d", want.data_out, m_tdata[23:16]);
            error_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    model_st = '0;
    model_st.ring_size = CFG_W'(RING_DEPTH);
    plan_st = model_st;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_phase(1'b0, RING_DEPTH, 0, 0, 1'b1, 330, 1'b0);
    run_phase(1'b1, 4, 46, 0, 1'b0, 300, 1'b0);
    run_phase(1'b1, 8191, 0, 46, 1'b0, 350, 1'b1);
    run_phase(1'b1, 3, 21, 21, 1'b0, 300, 1'b0);
    run_phase(1'b1, 37, 0, 0, 1'b0, 350, 1'b0);
    run_phase(1'b1, RING_DEPTH, 21, 21, 1'b0, 350, 1'b0);
    repeat (4) @(posedge clk);
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
